[hw/rtl/gcg_pkg.sv]
package gcg_pkg;

  localparam int CH_W    = 8;
  localparam int POS_W   = 7;
  localparam int COLOR_W = 24;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  // Grey ramp and color cube bases of the 256-color palette.
  localparam logic [7:0] GREY_BASE  = 8'd232;
  localparam logic [7:0] CUBE_BASE  = 8'd16;
  localparam logic [7:0] CUBE_RED   = 8'd36;
  localparam logic [7:0] CUBE_GREEN = 8'd6;

  // Rounded division by 11 and by 51 through fixed-point reciprocals. Both
  // are exact over the eight-bit channel range.
  localparam logic [8:0]  GREY_HALF   = 9'd5;
  localparam logic [17:0] GREY_RECIP  = 18'd373;
  localparam int          GREY_SHIFT  = 12;
  localparam logic [8:0]  CUBE_HALF   = 9'd25;
  localparam logic [17:0] CUBE_RECIP  = 18'd322;
  localparam int          CUBE_SHIFT  = 14;

  typedef enum logic [1:0] {
    SPAN_FIRST,
    SPAN_SECOND,
    SPAN_FULL
  } span_sel_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  function automatic logic [4:0] grey_level(input logic [CH_W-1:0] c);
    logic [8:0]  v;
    logic [17:0] p;
    v = {1'b0, c} + GREY_HALF;
    p = 18'(v) * GREY_RECIP;
    return p[GREY_SHIFT +: 5];
  endfunction

  function automatic logic [2:0] cube_level(input logic [CH_W-1:0] c);
    logic [8:0]  v;
    logic [17:0] p;
    v = {1'b0, c} + CUBE_HALF;
    p = 18'(v) * CUBE_RECIP;
    return p[CUBE_SHIFT +: 3];
  endfunction

  function automatic logic [7:0] palette_of(input logic [CH_W-1:0] r,
                                            input logic [CH_W-1:0] g,
                                            input logic [CH_W-1:0] b);
    logic [4:0] gr;
    logic [4:0] gg;
    logic [4:0] gb;
    logic [7:0] idx;
    gr = grey_level(r);
    gg = grey_level(g);
    gb = grey_level(b);
    if (gr == gg && gr == gb) begin
      idx = GREY_BASE + 8'(gr);
    end else begin
      idx = CUBE_BASE + 8'(cube_level(r)) * CUBE_RED
          + 8'(cube_level(g)) * CUBE_GREEN + 8'(cube_level(b));
    end
    return idx;
  endfunction

endpackage

[hw/rtl/gcg_lerp.sv]
module gcg_lerp
  import gcg_pkg::*;
#(
  parameter int LAST_POSITION = 100
) (
  input  logic                          clk,
  input  stage_en_t                     en,
  input  logic [$clog2(LAST_POSITION+1)-1:0] k_in,
  input  span_sel_t                     sel_in,
  input  logic [CH_W-1:0]               a_in,
  input  logic [CH_W-1:0]               b_in,
  output logic [CH_W-1:0]               chan_out
);

  localparam int KW    = $clog2(LAST_POSITION + 1);
  localparam int HALF  = LAST_POSITION / 2;
  localparam int SPAN2 = LAST_POSITION - HALF;
  localparam int NW    = KW + CH_W;
  localparam int SH    = NW + 2;
  localparam int MW    = SH + 1;
  localparam int PW    = NW + MW;

  localparam logic [MW-1:0] RECIP_FIRST  = MW'((64'd1 << SH) / HALF);
  localparam logic [MW-1:0] RECIP_SECOND = MW'((64'd1 << SH) / SPAN2);
  localparam logic [MW-1:0] RECIP_FULL   = MW'((64'd1 << SH) / LAST_POSITION);

  function automatic logic [KW-1:0] span_of(input span_sel_t sel);
    logic [KW-1:0] s;
    case (sel)
      SPAN_FIRST:  s = KW'(HALF);
      SPAN_SECOND: s = KW'(SPAN2);
      default:     s = KW'(LAST_POSITION);
    endcase
    return s;
  endfunction

  function automatic logic [MW-1:0] recip_of(input span_sel_t sel);
    logic [MW-1:0] m;
    case (sel)
      SPAN_FIRST:  m = RECIP_FIRST;
      SPAN_SECOND: m = RECIP_SECOND;
      default:     m = RECIP_FULL;
    endcase
    return m;
  endfunction

  // Stage 1: difference magnitude and sign.
  logic [CH_W-1:0] a1_r, mag1_r;
  logic            neg1_r;
  logic [KW-1:0]   k1_r;
  span_sel_t       sel1_r;
  // Stage 2: numerator.
  logic [CH_W-1:0] a2_r;
  logic            neg2_r;
  span_sel_t       sel2_r;
  logic [NW-1:0]   n2_r;
  // Stage 3: quotient estimate.
  logic [CH_W-1:0] a3_r, q3_r;
  logic            neg3_r;
  span_sel_t       sel3_r;
  logic [NW-1:0]   n3_r;
  // Stage 4: estimate times span.
  logic [CH_W-1:0] a4_r, q4_r;
  logic            neg4_r;
  span_sel_t       sel4_r;
  logic [NW-1:0]   n4_r, prod4_r;
  // Stage 5: channel.
  logic [CH_W-1:0] chan5_r;

  logic [CH_W:0]   diff;
  logic [CH_W-1:0] mag1_nxt;
  logic [NW-1:0]   n2_nxt;
  logic [PW-1:0]   p3;
  logic [CH_W-1:0] q3_nxt;
  logic [NW-1:0]   prod4_nxt;
  logic [NW-1:0]   rem5;
  logic [CH_W-1:0] q5;
  logic [CH_W-1:0] chan5_nxt;

  always_comb begin
    diff      = {1'b0, b_in} - {1'b0, a_in};
    mag1_nxt  = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
    n2_nxt    = NW'(k1_r) * NW'(mag1_r);
    p3        = PW'(n2_r) * PW'(recip_of(sel2_r));
    q3_nxt    = p3[SH +: CH_W];
    prod4_nxt = NW'(q3_r) * NW'(span_of(sel3_r));
    // The estimate is low by at most one; the remainder tells.
    rem5      = n4_r - prod4_r;
    q5        = q4_r + CH_W'(rem5 >= NW'(span_of(sel4_r)));
    chan5_nxt = neg4_r ? (a4_r - q5) : (a4_r + q5);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      a1_r   <= a_in;
      mag1_r <= mag1_nxt;
      neg1_r <= diff[CH_W];
      k1_r   <= k_in;
      sel1_r <= sel_in;
    end
    if (en.s2) begin
      a2_r   <= a1_r;
      neg2_r <= neg1_r;
      sel2_r <= sel1_r;
      n2_r   <= n2_nxt;
    end
    if (en.s3) begin
      a3_r   <= a2_r;
      neg3_r <= neg2_r;
      sel3_r <= sel2_r;
      n3_r   <= n2_r;
      q3_r   <= q3_nxt;
    end
    if (en.s4) begin
      a4_r    <= a3_r;
      neg4_r  <= neg3_r;
      sel4_r  <= sel3_r;
      n4_r    <= n3_r;
      q4_r    <= q3_r;
      prod4_r <= prod4_nxt;
    end
    if (en.s5) begin
      chan5_r <= chan5_nxt;
    end
  end

  assign chan_out = chan5_r;

endmodule

[hw/rtl/three_point_color_gradient_core.sv]
// Channel      | Direction | Handshake             | Payload
// input        | in        | in_valid / in_ready   | in_position
// result       | out       | out_valid / out_ready | out_red, out_green, out_blue,
//              |           |                       | out_palette_index, out_start_only
// config (APB) | in        | psel, penable, pready | paddr, pwdata, pwrite, prdata
//
// One transaction is accepted per clock while in_ready is high; its result
// passes through a position register, five interpolation stages (difference,
// product, reciprocal multiply, span multiply, correction and add) and the
// palette stage that loads the output register. The three channel multipliers
// set the stage boundaries. rst_n is synchronous and clears the configuration
// registers and every stage valid bit. A stalled output holds only the stages
// behind it that are occupied; empty stages keep filling, so bubbles collapse.
module three_point_color_gradient_core
  import gcg_pkg::*;
#(
  parameter int LAST_POSITION = 100
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input channel.
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [POS_W-1:0]  in_position,
  // Result channel.
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CH_W-1:0]   out_red,
  output logic [CH_W-1:0]   out_green,
  output logic [CH_W-1:0]   out_blue,
  output logic [7:0]        out_palette_index,
  output logic              out_start_only,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int KW    = $clog2(LAST_POSITION + 1);
  localparam int HALF  = LAST_POSITION / 2;
  localparam int CW    = (KW > POS_W) ? KW : POS_W;
  localparam int NSTG  = 7;

  // Register map, word index.
  localparam logic [2:0] REG_START   = 3'd0;
  localparam logic [2:0] REG_MID     = 3'd1;
  localparam logic [2:0] REG_MID_DEF = 3'd2;
  localparam logic [2:0] REG_END     = 3'd3;
  localparam logic [2:0] REG_END_DEF = 3'd4;

  logic [COLOR_W-1:0] start_color_r, mid_color_r, end_color_r;
  logic               mid_defined_r, end_defined_r;
  logic [2:0]         reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_color_r <= '0;
      mid_color_r   <= '0;
      mid_defined_r <= 1'b0;
      end_color_r   <= '0;
      end_defined_r <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_START:   start_color_r <= pwdata[COLOR_W-1:0];
        REG_MID:     mid_color_r   <= pwdata[COLOR_W-1:0];
        REG_MID_DEF: mid_defined_r <= pwdata[0];
        REG_END:     end_color_r   <= pwdata[COLOR_W-1:0];
        REG_END_DEF: end_defined_r <= pwdata[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START:   prdata = CFG_DW'(start_color_r);
      REG_MID:     prdata = CFG_DW'(mid_color_r);
      REG_MID_DEF: prdata = CFG_DW'(mid_defined_r);
      REG_END:     prdata = CFG_DW'(end_color_r);
      REG_END_DEF: prdata = CFG_DW'(end_defined_r);
      default:     prdata = '0;
    endcase
  end

  // Stage valid bits; stage NSTG-1 is the output register. A stage advances
  // when it is empty or when the stage after it advances.
  logic [NSTG-1:0] v_r, v_nxt, en;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int i = 1; i < NSTG; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTG-1];

  // Stage 0: positions past the end saturate to the last entry.
  logic [CW-1:0] pos_ext;
  logic [KW-1:0] pos0_r;

  assign pos_ext = CW'(in_position);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pos0_r <= (pos_ext > CW'(LAST_POSITION)) ? KW'(LAST_POSITION) : KW'(pos_ext);
    end
  end

  // Pick the span and its end points. With no end color both points are the
  // start color, so every channel lands on the start value.
  span_sel_t     sel0;
  logic [KW-1:0] k0;
  logic          lo_first;
  logic [COLOR_W-1:0] ca0, cb0;

  always_comb begin
    lo_first = pos0_r <= KW'(HALF);
    sel0     = SPAN_FULL;
    k0       = pos0_r;
    ca0      = start_color_r;
    cb0      = start_color_r;
    if (end_defined_r) begin
      if (mid_defined_r) begin
        if (lo_first) begin
          sel0 = SPAN_FIRST;
          cb0  = mid_color_r;
        end else begin
          sel0 = SPAN_SECOND;
          k0   = pos0_r - KW'(HALF);
          ca0  = mid_color_r;
          cb0  = end_color_r;
        end
      end else begin
        cb0 = end_color_r;
      end
    end
  end

  stage_en_t       lerp_en;
  logic [CH_W-1:0] red5, green5, blue5;

  assign lerp_en = '{s1: en[1], s2: en[2], s3: en[3], s4: en[4], s5: en[5]};

  gcg_lerp #(.LAST_POSITION(LAST_POSITION)) u_lerp_red (
    .clk      (clk),
    .en       (lerp_en),
    .k_in     (k0),
    .sel_in   (sel0),
    .a_in     (ca0[23:16]),
    .b_in     (cb0[23:16]),
    .chan_out (red5)
  );

  gcg_lerp #(.LAST_POSITION(LAST_POSITION)) u_lerp_green (
    .clk      (clk),
    .en       (lerp_en),
    .k_in     (k0),
    .sel_in   (sel0),
    .a_in     (ca0[15:8]),
    .b_in     (cb0[15:8]),
    .chan_out (green5)
  );

  gcg_lerp #(.LAST_POSITION(LAST_POSITION)) u_lerp_blue (
    .clk      (clk),
    .en       (lerp_en),
    .k_in     (k0),
    .sel_in   (sel0),
    .a_in     (ca0[7:0]),
    .b_in     (cb0[7:0]),
    .chan_out (blue5)
  );

  // The start-only flag rides alongside the channel stages.
  logic [5:1] only_r;

  always_ff @(posedge clk) begin
    if (en[1]) only_r[1] <= !end_defined_r;
    for (int i = 2; i <= 5; i++) begin
      if (en[i]) only_r[i] <= only_r[i-1];
    end
  end

  // Stage 6: palette lookup into the output register.
  logic [CH_W-1:0] red_r, green_r, blue_r;
  logic [7:0]      palette_r;
  logic            start_only_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      red_r        <= red5;
      green_r      <= green5;
      blue_r       <= blue5;
      palette_r    <= palette_of(red5, green5, blue5);
      start_only_r <= only_r[5];
    end
  end

  assign out_red           = red_r;
  assign out_green         = green_r;
  assign out_blue          = blue_r;
  assign out_palette_index = palette_r;
  assign out_start_only    = start_only_r;

endmodule
